>>> sv/tftr_pkg.sv
`default_nettype none
package tftr_pkg;

   localparam int unsigned TAG_BYTES     = 4;
   localparam logic [31:0] TAG_RESET     = 32'h6372_7368;
   localparam logic [4:0]  WPF_RESET     = 5'd6;
   localparam int unsigned CSR_IDX_W     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_TAG       = 2'd0,
      CSR_TAG_ENABLE      = 2'd1,
      CSR_WORDS_PER_FRAME = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FRAME_NONE   = 2'd0,
      FRAME_ACCEPT = 2'd1,
      FRAME_REJECT = 2'd2
   } frame_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0] frame_tag;
      logic        tag_enable;
      logic [4:0]  words_per_frame;
   } cfg_type;

   typedef struct packed {
      logic             tx_valid;
      logic [7:0]       tx_byte;
      frame_status_type frame_status;
      logic [7:0]       fill_level;
   } result_type;

endpackage
`default_nettype wire

>>> sv/tftr_ram.sv
`default_nettype none
module tftr_ram #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/tftr_ctrl.sv
`default_nettype none
module tftr_ctrl #(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tftr_pkg::cfg_type    cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [31:0]          req_data_word,
   input  wire logic                 req_tx_fifo_full,
   output logic                      res_valid,
   input  wire logic                 res_ready,
   output tftr_pkg::result_type      res
);
   import tftr_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = ((CW > 8) ? CW : 8) + 1;

   ctrl_state_type   state_ff, state_in;
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [4:0]       wpos_ff, wpos_in;
   logic             drop_ff, drop_in;
   logic [63:0]      shift_ff, shift_in;
   logic [3:0]       left_ff, left_in;
   frame_status_type status_ff, status_in;
   logic             txv_ff, txv_in;

   logic             wr_en, rd_en;
   logic [PW-1:0]    wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       rd_data;
   logic [4:0]       wpf;
   logic [7:0]       need;
   logic             fits;

   tftr_ram #(.DEPTH(DEPTH), .AW(PW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rptr_ff),
      .rd_data (rd_data)
   );

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wpf  = (cfg.words_per_frame == 5'd0) ? 5'd1 : cfg.words_per_frame;
   assign need = {({1'b0, wpf} + {5'd0, cfg.tag_enable}), 2'b00};
   assign fits = (SW'(count_ff) + SW'(need)) <= SW'(DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
         wpos_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
         wpos_ff  <= wpos_in;
         drop_ff  <= drop_in;
      end
      shift_ff  <= shift_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      txv_ff    <= txv_in;
   end

   always_comb begin
      state_in  = state_ff;
      wptr_in   = wptr_ff;
      rptr_in   = rptr_ff;
      count_in  = count_ff;
      wpos_in   = wpos_ff;
      drop_in   = drop_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      status_in = status_ff;
      txv_in    = txv_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wptr_ff;
      wr_data   = shift_ff[7:0];
      rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               txv_in    = 1'b0;
               status_in = FRAME_NONE;
               if (!req_type) begin
                  if (wpos_ff == 5'd0) begin
                     drop_in   = !fits;
                     status_in = fits ? FRAME_ACCEPT : FRAME_REJECT;
                  end
                  if (wpos_ff == 5'd0 && fits && cfg.tag_enable) begin
                     shift_in = {req_data_word, cfg.frame_tag};
                     left_in  = 4'd8;
                  end else begin
                     shift_in = {32'd0, req_data_word};
                     left_in  = drop_in ? 4'd0 : 4'd4;
                  end
                  if (({1'b0, wpos_ff} + 6'd1) >= {1'b0, wpf}) begin
                     wpos_in = 5'd0;
                  end else begin
                     wpos_in = wpos_ff + 5'd1;
                  end
                  state_in = (left_in != 4'd0) ? ST_PUSH : ST_DONE;
               end else begin
                  if (count_ff != '0 && !req_tx_fifo_full) begin
                     rd_en    = 1'b1;
                     rptr_in  = ptr_next(rptr_ff);
                     count_in = count_ff - CW'(1);
                     txv_in   = 1'b1;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_PUSH: begin
            if (count_ff < CW'(DEPTH)) begin
               wr_en    = 1'b1;
               wptr_in  = ptr_next(wptr_ff);
               count_in = count_ff + CW'(1);
            end
            shift_in = {8'd0, shift_ff[63:8]};
            left_in  = left_ff - 4'd1;
            if (left_ff == 4'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.tx_valid     = txv_ff;
   assign res.tx_byte      = txv_ff ? rd_data : 8'd0;
   assign res.frame_status = status_ff;
   assign res.fill_level   = 8'(count_ff);

endmodule
`default_nettype wire

>>> sv/tagged_frame_uart_tx_ring.sv
`default_nettype none
// Byte ring buffer in front of a UART transmitter. A frame word (req_type 0)
// is admitted all or nothing on a frame's first word; its bytes, with the
// four tag bytes first when tagging is on, go into the ring one per cycle
// through the single write port of the byte memory. A transmit slot
// (req_type 1) reads one byte from the memory when the ring is not empty and
// the transmit FIFO is not full. Every transfer on req_ gives exactly one
// transfer on rsp_. Each item is taken in the idle state, its bytes are then
// written, and its result is then passed on; a transmit slot or a dropped
// word writes no bytes. The next item is taken once the result sits in the
// output register, so a stalled rsp_ holds off req_.
module tagged_frame_uart_tx_ring #(
   parameter int unsigned BUFFER_DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_data_word,
   input  wire logic        req_tx_fifo_full,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic [1:0]       rsp_frame_status,
   output logic [7:0]       rsp_fill_level,
   input  wire logic        csr_write_en,
   input  wire tftr_pkg::csr_index_type csr_index,
   input  wire logic [31:0] csr_wdata
);
   import tftr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type rsp_ff;
   result_type res;
   logic       rsp_valid_ff;
   logic       res_valid, res_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_TAG:       cfg_in.frame_tag       = csr_wdata;
            CSR_TAG_ENABLE:      cfg_in.tag_enable      = csr_wdata[0];
            CSR_WORDS_PER_FRAME: cfg_in.words_per_frame = csr_wdata[4:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_tag       <= TAG_RESET;
         cfg_ff.tag_enable      <= 1'b1;
         cfg_ff.words_per_frame <= WPF_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   tftr_ctrl #(.DEPTH(BUFFER_DEPTH)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_data_word    (req_data_word),
      .req_tx_fifo_full (req_tx_fifo_full),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_valid     = rsp_ff.tx_valid;
   assign rsp_tx_byte      = rsp_ff.tx_byte;
   assign rsp_frame_status = rsp_ff.frame_status;
   assign rsp_fill_level   = rsp_ff.fill_level;

endmodule
`default_nettype wire

>>> tb/sv/tb_tagged_frame_uart_tx_ring.sv
`timescale 1ns / 100ps

module tb_tagged_frame_uart_tx_ring;
   import tftr_pkg::*;

   localparam int unsigned BUFFER_DEPTH = 128;
   localparam logic        REQ_WORD = 1'b0;
   localparam logic        REQ_SLOT = 1'b1;
   localparam logic [1:0]  CSR_IDX_SPARE = 2'd3;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          RANDOM_PHASES = 10;
   localparam int          PHASE_ITEMS = 90;

   typedef struct {
      logic        req_type;
      logic [31:0] word;
      logic        full;
   } ring_req_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_type = REQ_SLOT;
   logic [31:0]   req_data_word = '0;
   logic          req_tx_fifo_full = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_tx_valid;
   logic [7:0]    rsp_tx_byte;
   logic [1:0]    rsp_frame_status;
   logic [7:0]    rsp_fill_level;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index = CSR_FRAME_TAG;
   logic [31:0]   csr_wdata = '0;

   tagged_frame_uart_tx_ring #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_data_word(req_data_word),
      .req_tx_fifo_full(req_tx_fifo_full),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_frame_status(rsp_frame_status),
      .rsp_fill_level(rsp_fill_level),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow copy of the ring and its registers
   logic [31:0] cfg_tag = TAG_RESET;
   logic        cfg_tag_en = 1'b1;
   logic [4:0]  cfg_wpf = WPF_RESET;
   logic [7:0]  shadow_bytes [BUFFER_DEPTH];
   logic [6:0]  shadow_wr_ptr = '0;
   logic [6:0]  shadow_rd_ptr = '0;
   int          shadow_count = 0;
   int          shadow_word_idx = 0;
   logic        shadow_dropping = 1'b0;

   ring_req_t   pending_reqs[$];
   result_type  expected_results[$];
   ring_req_t   cur_req;
   int          reqs_queued = 0;
   int          reqs_accepted = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;

   wire calm = reqs_accepted >= 700 && reqs_accepted < 850;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
               what, results_seen, got, want);
   endtask

   function automatic void push_ring_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) begin
         if (shadow_count < BUFFER_DEPTH) begin
            shadow_bytes[shadow_wr_ptr] = w[8*i +: 8];
            shadow_wr_ptr++;
            shadow_count++;
         end
      end
   endfunction

   function automatic result_type predict_ring_result(ring_req_t r);
      result_type res;
      int wpf;
      int need;
      res = '0;
      res.frame_status = FRAME_NONE;
      if (r.req_type == REQ_WORD) begin
         wpf = (cfg_wpf == 0) ? 1 : int'(cfg_wpf);
         if (shadow_word_idx == 0) begin
            need = (wpf + int'(cfg_tag_en)) * TAG_BYTES;
            if (shadow_count + need <= BUFFER_DEPTH) begin
               shadow_dropping = 1'b0;
               res.frame_status = FRAME_ACCEPT;
               if (cfg_tag_en)
                  push_ring_word(cfg_tag);
            end else begin
               shadow_dropping = 1'b1;
               res.frame_status = FRAME_REJECT;
            end
         end
         if (!shadow_dropping)
            push_ring_word(r.word);
         if (shadow_word_idx + 1 >= wpf)
            shadow_word_idx = 0;
         else
            shadow_word_idx++;
      end else if (shadow_count > 0 && !r.full) begin
         res.tx_valid = 1'b1;
         res.tx_byte = shadow_bytes[shadow_rd_ptr];
         shadow_rd_ptr++;
         shadow_count--;
      end
      res.fill_level = shadow_count[7:0];
      return res;
   endfunction

   // driver: offers pending requests, predicts on each transfer
   always @(posedge clock) begin : drive_reqs
      ring_req_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_ring_result(cur_req));
            reqs_accepted <= reqs_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
               nxt = pending_reqs.pop_front();
               cur_req = nxt;
               req_type <= nxt.req_type;
               req_data_word <= nxt.word;
               req_tx_fifo_full <= nxt.full;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, with one long hold-off while requests keep coming
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && reqs_accepted >= 300 && pending_reqs.size() > 50) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 17;
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_fill_level), 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", 32'(rsp_tx_valid), 32'(want.tx_valid));
            if (rsp_tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 32'(rsp_tx_byte), 32'(want.tx_byte));
            if (rsp_frame_status !== want.frame_status)
               report_mismatch("frame_status", 32'(rsp_frame_status),
                               32'(want.frame_status));
            if (rsp_fill_level !== want.fill_level)
               report_mismatch("fill_level", 32'(rsp_fill_level), 32'(want.fill_level));
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_req(logic kind, logic [31:0] word, logic full);
      ring_req_t r;
      r.req_type = kind;
      r.word = word;
      r.full = full;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FRAME_TAG:       cfg_tag = value;
         CSR_TAG_ENABLE:      cfg_tag_en = value[0];
         CSR_WORDS_PER_FRAME: cfg_wpf = value[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_ring_idle();
      while (results_seen != reqs_queued)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // empties the ring, one extra slot hits the empty case
   task automatic drain_ring();
      int n;
      wait_ring_idle();
      n = shadow_count + 1;
      for (int i = 0; i < n; i++)
         queue_req(REQ_SLOT, $urandom, 1'b0);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int word_pct;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: tagged frames of six words
      queue_req(REQ_SLOT, 32'h0, 1'b0);
      queue_req(REQ_SLOT, 32'hFFFF_FFFF, 1'b1);
      queue_req(REQ_WORD, 32'h0000_0000, 1'b0);
      queue_req(REQ_WORD, 32'hFFFF_FFFF, 1'b1);
      queue_req(REQ_WORD, 32'h5555_5555, 1'b0);
      queue_req(REQ_WORD, 32'hAAAA_AAAA, 1'b0);
      queue_req(REQ_WORD, 32'h0000_0001, 1'b0);
      queue_req(REQ_WORD, 32'h8000_0000, 1'b0);
      queue_req(REQ_SLOT, 32'h0, 1'b1);
      for (int i = 0; i < 5; i++)
         queue_req(REQ_SLOT, 32'h0, 1'b0);
      wait_ring_idle();

      // zero frame length acts as one word, spare index is ignored
      write_csr(CSR_FRAME_TAG, 32'hFFFF_FFFF);
      write_csr(CSR_TAG_ENABLE, 32'h0);
      write_csr(CSR_WORDS_PER_FRAME, 32'h0);
      write_csr(csr_index_type'(CSR_IDX_SPARE), 32'hFFFF_FFFF);
      queue_req(REQ_WORD, 32'hDEAD_BEEF, 1'b0);
      queue_req(REQ_WORD, 32'h0123_4567, 1'b0);
      wait_ring_idle();
      write_csr(CSR_WORDS_PER_FRAME, 32'd3);
      queue_req(REQ_WORD, 32'h89AB_CDEF, 1'b0);
      wait_ring_idle();
      // shorten the frame while one is open
      write_csr(CSR_WORDS_PER_FRAME, 32'd1);
      queue_req(REQ_WORD, 32'hFEDC_BA98, 1'b0);
      drain_ring();
      wait_ring_idle();

      // fill to 124 bytes, then lengthen the open frame past capacity
      write_csr(CSR_WORDS_PER_FRAME, 32'd2);
      for (int i = 0; i < 31; i++)
         queue_req(REQ_WORD, pick_word(), $urandom_range(1));
      wait_ring_idle();
      write_csr(CSR_WORDS_PER_FRAME, 32'd31);
      for (int i = 0; i < 3; i++)
         queue_req(REQ_WORD, pick_word(), 1'b0);
      wait_ring_idle();
      write_csr(CSR_WORDS_PER_FRAME, 32'd1);
      write_csr(CSR_TAG_ENABLE, 32'h1);
      queue_req(REQ_WORD, 32'h1111_2222, 1'b0);
      queue_req(REQ_WORD, 32'h3333_4444, 1'b0);
      drain_ring();
      wait_ring_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(3))
            0:       write_csr(CSR_FRAME_TAG, 32'h0000_0000);
            1:       write_csr(CSR_FRAME_TAG, 32'hFFFF_FFFF);
            default: write_csr(CSR_FRAME_TAG, $urandom);
         endcase
         write_csr(CSR_TAG_ENABLE, (p < 2) ? p : $urandom_range(1));
         case ((p < 2) ? p : $urandom_range(5))
            0:       write_csr(CSR_WORDS_PER_FRAME, 32'd31);
            1:       write_csr(CSR_WORDS_PER_FRAME, 32'd1);
            default: write_csr(CSR_WORDS_PER_FRAME, $urandom_range(31, 1));
         endcase
         word_pct = (p % 2 == 0) ? 65 : 35;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < word_pct)
               queue_req(REQ_WORD, pick_word(), $urandom_range(1));
            else
               queue_req(REQ_SLOT, $urandom, $urandom_range(99) < 15);
         end
         wait_ring_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
sv/tftr_pkg.sv
sv/tftr_ram.sv
sv/tftr_ctrl.sv
sv/tagged_frame_uart_tx_ring.sv
tb/sv/tb_tagged_frame_uart_tx_ring.sv
